// File: rtl/opcl_pkg.sv
// shared types and constants of the pixel-control to luminance block
package opcl_pkg;

  localparam int MAX_DIMMERS = 256;
  localparam int HDR_LEN     = 4;

  // header byte positions
  localparam logic [2:0] HDR_POS_LEN_HI = 3'd2;
  localparam logic [2:0] HDR_POS_LEN_LO = 3'd3;
  localparam logic [2:0] HDR_POS_DONE   = 3'(HDR_LEN);

  // byte positions within one rgb triple
  localparam logic [1:0] TRI_RED   = 2'd0;
  localparam logic [1:0] TRI_GREEN = 2'd1;
  localparam logic [1:0] TRI_BLUE  = 2'd2;

  // fixed-point luma weights, sum is 65536
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  // reciprocal of 3, exact for 16-bit lengths with a 17-bit shift
  localparam int          DIV3_SHIFT = 17;
  localparam logic [16:0] DIV3_MUL   = 17'd43691;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0] dimmer_level;
    logic [7:0] dimmer_index;
    logic       last_dimmer;
    logic       truncated;
  } out_item_t;

  typedef struct packed {
    logic       produce;
    out_item_t  result;
  } ctrl_res_t;

endpackage

// File: rtl/opcl_stream_if.sv
// valid/ready channel carrying one item per handshake
interface opcl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/opcl_luma.sv
// weighted rgb to luminance byte
module opcl_luma (
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic [7:0] level
);

  logic [23:0] sum;

  always_comb begin
    sum = 24'(opcl_pkg::W_RED * 24'(red))
        + 24'(opcl_pkg::W_GREEN * 24'(green))
        + 24'(opcl_pkg::W_BLUE * 24'(blue));
  end

  // weights sum to 65536 so the top byte never overflows
  assign level = sum[23:16];

endmodule

// File: rtl/opcl_frame_ctrl.sv
// packet header parse, triple assembly and result decision
module opcl_frame_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  opcl_pkg::in_item_t  item,
  output opcl_pkg::ctrl_res_t res
);

  localparam logic [8:0] MAX_CNT = 9'(opcl_pkg::MAX_DIMMERS);

  logic [2:0] hdr_pos_r,   hdr_pos_nxt;
  logic [8:0] target_r,    target_nxt;
  logic [7:0] len_hi_r,    len_hi_nxt;
  logic [1:0] tri_pos_r,   tri_pos_nxt;
  logic [7:0] red_r,       red_nxt;
  logic [7:0] green_r,     green_nxt;
  logic [8:0] done_r,      done_nxt;

  logic [15:0] len;
  logic [32:0] div_prod;
  logic [15:0] cnt;
  logic [8:0]  cnt_capped;
  logic [7:0]  luma_level;
  logic        is_last;
  logic        eop;

  opcl_luma u_luma (
    .red   (red_r),
    .green (green_r),
    .blue  (item.data_byte),
    .level (luma_level)
  );

  assign eop        = item.end_of_packet;
  assign len        = {len_hi_r, item.data_byte};
  assign div_prod   = 33'(len) * 33'(opcl_pkg::DIV3_MUL);
  assign cnt        = div_prod[opcl_pkg::DIV3_SHIFT +: 16];
  assign cnt_capped = (cnt > 16'(MAX_CNT)) ? MAX_CNT : cnt[8:0];
  assign is_last    = (done_r + 9'd1) == target_r;

  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    target_nxt  = target_r;
    len_hi_nxt  = len_hi_r;
    tri_pos_nxt = tri_pos_r;
    red_nxt     = red_r;
    green_nxt   = green_r;
    done_nxt    = done_r;
    res         = '0;

    if (hdr_pos_r < opcl_pkg::HDR_POS_DONE) begin
      if (hdr_pos_r == opcl_pkg::HDR_POS_LEN_HI) begin
        len_hi_nxt = item.data_byte;
      end else if (hdr_pos_r == opcl_pkg::HDR_POS_LEN_LO) begin
        target_nxt = cnt_capped;
      end
      hdr_pos_nxt = hdr_pos_r + 3'd1;
      if (eop && hdr_pos_r == opcl_pkg::HDR_POS_LEN_LO && cnt_capped != 9'd0) begin
        res.produce            = 1'b1;
        res.result.last_dimmer = 1'b1;
        res.result.truncated   = 1'b1;
      end
    end else if (done_r < target_r) begin
      case (tri_pos_r)
        opcl_pkg::TRI_RED: begin
          red_nxt     = item.data_byte;
          tri_pos_nxt = opcl_pkg::TRI_GREEN;
        end
        opcl_pkg::TRI_GREEN: begin
          green_nxt   = item.data_byte;
          tri_pos_nxt = opcl_pkg::TRI_BLUE;
        end
        default: begin
          tri_pos_nxt = opcl_pkg::TRI_RED;
          if (!eop || is_last) begin
            res.produce             = 1'b1;
            res.result.dimmer_level = luma_level;
            res.result.dimmer_index = done_r[7:0];
            res.result.last_dimmer  = is_last;
            done_nxt                = done_r + 9'd1;
          end
        end
      endcase
      // early end of packet
      if (eop && !res.produce) begin
        res.produce             = 1'b1;
        res.result.dimmer_index = done_r[7:0];
        res.result.last_dimmer  = 1'b1;
        res.result.truncated    = 1'b1;
      end
    end

    if (eop) begin
      hdr_pos_nxt = '0;
      target_nxt  = '0;
      len_hi_nxt  = '0;
      tri_pos_nxt = opcl_pkg::TRI_RED;
      red_nxt     = '0;
      green_nxt   = '0;
      done_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r <= '0;
      target_r  <= '0;
      len_hi_r  <= '0;
      tri_pos_r <= opcl_pkg::TRI_RED;
      red_r     <= '0;
      green_r   <= '0;
      done_r    <= '0;
    end else if (advance) begin
      hdr_pos_r <= hdr_pos_nxt;
      target_r  <= target_nxt;
      len_hi_r  <= len_hi_nxt;
      tri_pos_r <= tri_pos_nxt;
      red_r     <= red_nxt;
      green_r   <= green_nxt;
      done_r    <= done_nxt;
    end
  end

  a_done_le_target: assert property (@(posedge clk) disable iff (!rst_n)
    done_r <= target_r)
    else $error("dimmer count passed frame target");

  a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pos_r <= opcl_pkg::HDR_POS_DONE)
    else $error("header position out of range");

  a_trunc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    res.produce && res.result.truncated |->
      res.result.last_dimmer && res.result.dimmer_level == 8'd0)
    else $error("truncated result not marked last with zero level");

  a_eop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && eop |=> hdr_pos_r == 3'd0 && done_r == 9'd0 && target_r == 9'd0)
    else $error("frame state not cleared after end of packet");

endmodule

// File: rtl/opc_frame_rgb_to_luminance_unit.sv
// top level of the pixel-control packet to luminance converter
//
// in_ch takes one packet byte per item with end_of_packet on the final byte.
// bytes 0 and 1 are skipped, bytes 2 and 3 give a big-endian payload length;
// the frame declares min(length/3, 256) dimmers. each following rgb triple
// gives one out_ch item with its luminance level, dimmer index and a last
// flag. a packet that ends before its declared payload gives one item with
// truncated set, level zero and the index of the first missing dimmer.
// surplus payload bytes are dropped; every end of packet clears the frame.
//
// an accepted byte sits in the input register, where the header parse,
// the three constant-weight multiply-add and the result decision run; the
// result lands in the output register, so the byte that completes it passes
// the input register and then the output register before out_ch.valid rises.
// one item is taken every cycle while out_ch.ready is high or the output
// register is free.
// when the receiver stalls, the output register holds its item and the input
// register holds one more byte; in_ch.ready drops once both are full.
// reset is synchronous and clears the frame state and both valid flags.
module opc_frame_rgb_to_luminance_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  opcl_stream_if.sink          in_ch,
  opcl_stream_if.source        out_ch
);

  logic                s1_valid_r;
  opcl_pkg::in_item_t  s1_item_r;
  logic                out_valid_r;
  opcl_pkg::out_item_t out_item_r;

  opcl_pkg::ctrl_res_t ctrl_res;
  logic                out_free;
  logic                s1_adv;
  logic                in_fire;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && (!ctrl_res.produce || out_free);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  opcl_frame_ctrl u_frame_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .item    (s1_item_r),
    .res     (ctrl_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_ch.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && ctrl_res.produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && ctrl_res.produce) begin
      out_item_r <= ctrl_res.result;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !(s1_adv && ctrl_res.produce))
    else $error("pending result overwritten");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("valid flags not cleared by reset");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_free |-> s1_adv)
    else $error("input register stuck with free output");

endmodule
